// ===== rtl/cfdt_pkg.sv =====
// Shared types and constants for the charge-full debounce tracker.
package cfdt_pkg;

  // Published level limits
  localparam logic [6:0] LEVEL_CAP          = 7'd100;
  localparam logic [6:0] LEVEL_CHARGING_CAP = 7'd99;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN_VOLTAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN_LEVEL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DEBOUNCE    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_FULL_MIN_VOLTAGE = 16'd4100;
  localparam logic [6:0]  RST_FULL_MIN_LEVEL   = 7'd95;
  localparam logic [31:0] RST_FULL_DEBOUNCE    = 32'd30000;

  typedef enum logic [1:0] {
    CS_DISCHARGING = 2'd0,
    CS_CHARGING    = 2'd1,
    CS_FULL        = 2'd2
  } charge_state_e;

  typedef struct packed {
    logic [15:0] full_min_voltage_mv;
    logic [6:0]  full_min_level;
    logic [31:0] full_debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  level_in;
    logic        power_present;
    logic        raw_full_flag;
    logic        raw_charging_flag;
    logic        voltage_valid;
    logic [15:0] voltage_mv;
    logic [31:0] time_ms;
  } sample_t;

  typedef struct packed {
    charge_state_e charge_state;
    logic [6:0]    level_out;
    logic          power_out;
    logic          latched_out;
    logic [31:0]   candidate_age_ms;
  } result_t;

endpackage

// ===== rtl/cfdt_if.sv =====
// Valid/ready channel interfaces for status samples and tracker results.
interface cfdt_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  level_in;
  logic        power_present;
  logic        raw_full_flag;
  logic        raw_charging_flag;
  logic        voltage_valid;
  logic [15:0] voltage_mv;
  logic [31:0] time_ms;

  modport source (
    output valid, level_in, power_present, raw_full_flag, raw_charging_flag,
           voltage_valid, voltage_mv, time_ms,
    input  ready
  );
  modport sink (
    input  valid, level_in, power_present, raw_full_flag, raw_charging_flag,
           voltage_valid, voltage_mv, time_ms,
    output ready
  );
endinterface

interface cfdt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  charge_state;
  logic [6:0]  level_out;
  logic        power_out;
  logic        latched_out;
  logic [31:0] candidate_age_ms;

  modport source (
    output valid, charge_state, level_out, power_out, latched_out, candidate_age_ms,
    input  ready
  );
  modport sink (
    input  valid, charge_state, level_out, power_out, latched_out, candidate_age_ms,
    output ready
  );
endinterface

// ===== rtl/charge_full_debounce_tracker_unit.sv =====
// Top level of the charge-full debounce tracker.
// Each status sample yields one result item. A sample is captured in an input
// register, then evaluated combinationally by the debounce logic against the
// full latch and run start, and the result lands in an output register; the
// result is valid once the sample has passed the input and output registers,
// and one sample is accepted every cycle as long as the output is taken, the rate set
// by the single compare-and-subtract state update per item. Configuration
// writes go to the threshold and debounce registers and take effect for
// following samples.
module charge_full_debounce_tracker_unit
  import cfdt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cfdt_in_if.sink               in_i,
  cfdt_out_if.source            out_o
);

  cfg_t    cfg;
  sample_t s1_q, s1_d;
  logic    s1_valid_q, s1_adv;
  result_t res, out_q;
  logic    out_valid_q;

  cfdt_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Handshake: the input stage moves on whenever the output register is free
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    s1_d.level_in          = in_i.level_in;
    s1_d.power_present     = in_i.power_present;
    s1_d.raw_full_flag     = in_i.raw_full_flag;
    s1_d.raw_charging_flag = in_i.raw_charging_flag;
    s1_d.voltage_valid     = in_i.voltage_valid;
    s1_d.voltage_mv        = in_i.voltage_mv;
    s1_d.time_ms           = in_i.time_ms;
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s1_q <= s1_d;
  end

  cfdt_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (s1_adv),
    .sample_i (s1_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) out_q <= res;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.charge_state     = out_q.charge_state;
  assign out_o.level_out        = out_q.level_out;
  assign out_o.power_out        = out_q.power_out;
  assign out_o.latched_out      = out_q.latched_out;
  assign out_o.candidate_age_ms = out_q.candidate_age_ms;

endmodule

// ===== rtl/cfdt_cfg.sv =====
// Configuration register file: thresholds and debounce time.
module cfdt_cfg
  import cfdt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Register decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FULL_MIN_VOLTAGE: cfg_d.full_min_voltage_mv = cfg_data_i[15:0];
        REG_FULL_MIN_LEVEL:   cfg_d.full_min_level      = cfg_data_i[6:0];
        REG_FULL_DEBOUNCE:    cfg_d.full_debounce_ms    = cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_min_voltage_mv <= RST_FULL_MIN_VOLTAGE;
      cfg_q.full_min_level      <= RST_FULL_MIN_LEVEL;
      cfg_q.full_debounce_ms    <= RST_FULL_DEBOUNCE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/cfdt_step.sv =====
// Debounce state (full latch, run start) and per-item result logic.
module cfdt_step
  import cfdt_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    adv_i,
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic        latch_q, latch_d;
  logic [31:0] start_q, start_d;
  logic        pwr, allows, cand;
  logic [31:0] diff;
  logic [6:0]  pub;

  // Candidate test against thresholds
  assign pwr    = sample_i.power_present | sample_i.raw_full_flag;
  assign allows = !sample_i.voltage_valid
                | (sample_i.voltage_mv >= cfg_i.full_min_voltage_mv)
                | (sample_i.level_in >= {1'b0, cfg_i.full_min_level});
  assign cand   = sample_i.raw_full_flag & !sample_i.raw_charging_flag & allows;
  assign diff   = sample_i.time_ms - start_q;
  assign pub    = (sample_i.level_in > {1'b0, LEVEL_CAP}) ? LEVEL_CAP
                                                          : sample_i.level_in[6:0];

  // Next latch and run start; a start of zero means no run
  always_comb begin
    latch_d = latch_q;
    start_d = start_q;
    if (!pwr) begin
      latch_d = 1'b0;
      start_d = '0;
    end else if (!latch_q) begin
      if (!cand) begin
        start_d = '0;
      end else if (start_q == '0) begin
        start_d = sample_i.time_ms;
      end else if (diff >= cfg_i.full_debounce_ms) begin
        latch_d = 1'b1;
      end
    end
  end

  // Result fields
  always_comb begin
    result_o.power_out        = pwr;
    result_o.latched_out      = latch_d;
    // a freshly started run has age zero
    result_o.candidate_age_ms = (start_d != '0 && start_d == start_q) ? diff : '0;
    result_o.level_out        = pub;
    if (latch_d) begin
      result_o.charge_state = CS_FULL;
      result_o.level_out    = LEVEL_CAP;
    end else if (pwr && sample_i.raw_charging_flag) begin
      result_o.charge_state = CS_CHARGING;
      if (pub >= LEVEL_CAP) result_o.level_out = LEVEL_CHARGING_CAP;
    end else begin
      result_o.charge_state = CS_DISCHARGING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q <= 1'b0;
      start_q <= '0;
    end else if (adv_i) begin
      latch_q <= latch_d;
      start_q <= start_d;
    end
  end

  // A latch always belongs to a run that has a start time
  a_latch_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> start_q != '0)
    else $error("full latch set without a run start");

  // Losing power clears all tracking state
  a_no_power_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && !pwr |=> !latch_q && start_q == '0)
    else $error("state not cleared on power loss");

  // While latched with power, the run start stays frozen
  a_latched_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && latch_q && pwr |=> latch_q && $stable(start_q))
    else $error("latched run start moved");

  // The state holds while no item advances
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(latch_q) && $stable(start_q))
    else $error("state changed without an item");

endmodule
